// ===== rtl/core/tla_pkg.sv =====
// Shared types, byte codes and sizes for the text line assembler.
package tla_pkg;

  // Line store geometry and run limits.
  localparam int STORE_DEPTH       = 64;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int FILL_W            = 7;
  localparam int CHAR_W            = 7;
  localparam int MAX_RESULTS       = 63;
  localparam int LINE_CAPACITY_DEF = 64;

  // Byte codes seen on the host bus.
  localparam logic [7:0]        STOP_HI  = 8'h90;
  localparam logic [7:0]        STOP_ETX = 8'h03;
  localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 7'h0a;
  localparam logic [CHAR_W-1:0] CH_VT    = 7'h0b;
  localparam logic [CHAR_W-1:0] CH_CR    = 7'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7f;

  // Item kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_STOP = 1'b1;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_out;
    logic              last_of_run;
    logic              utterance_end;
  } item_t;

  // Access to the line memory for one cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic              idle;
    logic [FILL_W-1:0] fill;
  } ctrl_status_t;

endpackage

// ===== rtl/core/tla_line_mem.sv =====
// Line store: one write port and one registered read port.
module tla_line_mem
  import tla_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [STORE_DEPTH];

  // Write and registered read; read data holds between reads.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/core/tla_ctrl.sv =====
// Byte decoder, fill count and flush sequencer of the text line assembler.
module tla_ctrl
  import tla_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        byte_in,
  output logic              in_ready,
  input  logic              out_free,
  output logic              push,
  output item_t             item,
  output mem_req_t          mem_req,
  input  logic [CHAR_W-1:0] rdata,
  output ctrl_status_t      status
);

  localparam int FULL_AT = LINE_CAPACITY - 2;
  localparam int FIN_MAX = MAX_RESULTS - 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_OUT  = 4'b0100,
    S_VT   = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;
  logic [ADDR_W-1:0] last_idx, last_idx_next;
  logic              finish_run, finish_run_next;
  logic [CHAR_W-1:0] pend_char, pend_char_next;

  assign in_ready = (state == S_IDLE) && out_free;

  assign status.idle = (state == S_IDLE);
  assign status.fill = fill_count;

  // Next-state logic: decode in idle, then read out the line one entry at a time.
  always_comb begin
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] store_ch;
    ch              = byte_in[CHAR_W-1:0];
    store_ch        = (ch == CH_TAB) ? CH_SPACE : ch;
    state_next      = state;
    fill_count_next = fill_count;
    rd_idx_next     = rd_idx;
    last_idx_next   = last_idx;
    finish_run_next = finish_run;
    pend_char_next  = pend_char;
    push            = 1'b0;
    item            = '0;
    mem_req         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (byte_in == STOP_HI || byte_in == STOP_ETX) begin
            fill_count_next = '0;
            push            = 1'b1;
            item.kind       = KIND_STOP;
            item.last_of_run = 1'b1;
          end else begin
            unique case (ch) inside
              CH_BS, CH_DEL: begin
                if (fill_count != '0) begin
                  fill_count_next = fill_count - FILL_W'(1);
                end
              end
              CH_CR, CH_LF, CH_VT: begin
                if (fill_count != '0) begin
                  finish_run_next = 1'b1;
                  rd_idx_next     = '0;
                  last_idx_next   = (fill_count > FILL_W'(FIN_MAX)) ?
                                    ADDR_W'(FIN_MAX - 1) :
                                    fill_count[ADDR_W-1:0] - ADDR_W'(1);
                  state_next      = S_RD;
                end
              end
              default: begin
                // Tab and printable characters are stored; other controls drop.
                if (ch == CH_TAB || ch >= CH_SPACE) begin
                  if (fill_count >= FILL_W'(FULL_AT)) begin
                    finish_run_next = 1'b0;
                    rd_idx_next     = '0;
                    last_idx_next   = fill_count[ADDR_W-1:0] - ADDR_W'(1);
                    pend_char_next  = store_ch;
                    state_next      = S_RD;
                  end else begin
                    mem_req.we      = 1'b1;
                    mem_req.waddr   = fill_count[ADDR_W-1:0];
                    mem_req.wdata   = store_ch;
                    fill_count_next = fill_count + FILL_W'(1);
                  end
                end
              end
            endcase
          end
        end
      end
      S_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_idx;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          push             = 1'b1;
          item.kind        = KIND_TEXT;
          item.char_out    = rdata;
          item.last_of_run = !finish_run && (rd_idx == last_idx);
          if (rd_idx == last_idx) begin
            if (finish_run) begin
              state_next = S_VT;
            end else begin
              // The held character starts the new line.
              mem_req.we      = 1'b1;
              mem_req.waddr   = '0;
              mem_req.wdata   = pend_char;
              fill_count_next = FILL_W'(1);
              state_next      = S_IDLE;
            end
          end else begin
            rd_idx_next = rd_idx + ADDR_W'(1);
            state_next  = S_RD;
          end
        end
      end
      S_VT: begin
        if (out_free) begin
          push               = 1'b1;
          item.kind          = KIND_TEXT;
          item.char_out      = CH_VT;
          item.last_of_run   = 1'b1;
          item.utterance_end = 1'b1;
          fill_count_next    = '0;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
  end

  // Run bookkeeping needs no reset.
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    last_idx   <= last_idx_next;
    finish_run <= finish_run_next;
    pend_char  <= pend_char_next;
  end

endmodule

// ===== rtl/core/text_line_assembler_top.sv =====
// Top level of the text line assembler: controller, line store and output register.
//
// Raw bytes arrive one item per handshake and are gathered into a 64-entry line
// store. A byte that only edits or extends the line, or a stop byte, is taken
// without starting a flush. A line-end byte or a printable byte that finds the
// line full starts a flush: the stored characters are read back one at a time,
// each by first issuing the read of the line memory and then loading the
// registered read data into the output register, followed on a line end by the
// closing VT item; the input is held from the byte that started the flush until
// it ends, including any time the output side stalls. Results leave through one
// output register, and a byte is taken only while that register is empty or is
// being emptied in the same cycle.
module text_line_assembler_top
  import tla_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [CHAR_W-1:0] char_out,
  output logic              last_of_run,
  output logic              utterance_end
);

  logic              out_free;
  logic              push;
  item_t             item;
  item_t             out_item;
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] rdata;
  ctrl_status_t      status;

  assign out_free = !out_valid || out_ready;

  tla_ctrl #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .byte_in  (byte_in),
    .in_ready (in_ready),
    .out_free (out_free),
    .push     (push),
    .item     (item),
    .mem_req  (mem_req),
    .rdata    (rdata),
    .status   (status)
  );

  tla_line_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= item;
    end
  end

  assign kind          = out_item.kind;
  assign char_out      = out_item.char_out;
  assign last_of_run   = out_item.last_of_run;
  assign utterance_end = out_item.utterance_end;

  // The controller only loads the output register when it is free.
  assert property (@(posedge clk) disable iff (rst) push |-> out_free)
    else $error("item pushed into an occupied output register");

  // Bytes are only taken while no flush is running.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |-> status.idle)
    else $error("byte accepted during a flush");

  // The line never holds more than capacity minus two characters.
  assert property (@(posedge clk) disable iff (rst)
                   status.fill <= FILL_W'(LINE_CAPACITY - 2))
    else $error("fill count beyond line capacity");

  // A finished utterance closes its run.
  assert property (@(posedge clk) disable iff (rst)
                   (push && item.utterance_end) |=> (status.idle && status.fill == '0))
    else $error("utterance end did not clear the line");

endmodule

// ===== sim/text_line_assembler_top_test.sv =====
// Self-checking testbench for the text line assembler: random byte stream, shadow line model.
`timescale 1ns / 1ps

module text_line_assembler_top_test;
  import tla_pkg::*;

  localparam int LINE_CAP     = LINE_CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 140;
  // A flush of a full line plus a closing item, with room for output stalls.
  localparam int DRAIN_CYCLES = 4 * MAX_RESULTS + 100;
  localparam int LONG_HOLD    = 400;
  // Even if every byte caused a full run of results and each result waited out
  // the longest receiver stall, a clean run would stay under a quarter of this.
  localparam int CYCLE_LIMIT  = 4000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        byte_in = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              kind;
  logic [CHAR_W-1:0] char_out;
  logic              last_of_run;
  logic              utterance_end;

  // Bytes waiting to be offered and results the shadow line has produced.
  logic [7:0] pending_bytes[$];
  item_t      expected_items[$];

  // Shadow copy of the line being assembled.
  logic [CHAR_W-1:0] line_chars[STORE_DEPTH];
  int unsigned       line_len = 0;

  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_quiet = 0;
  int recv_gap = 0;
  int recv_quiet = 0;
  bit long_hold_done = 1'b0;

  text_line_assembler_top #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .char_out(char_out),
    .last_of_run(last_of_run),
    .utterance_end(utterance_end)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // A printable character, with bit 7 set about one time in five.
  function automatic logic [7:0] printable_byte();
    logic [6:0] ch;
    ch = 7'($urandom_range(CH_SPACE, CH_DEL - 1));
    return {($urandom_range(0, 4) == 0), ch};
  endfunction

  // Emits the stored line as a run, closed by a VT item when the line ends.
  task automatic emit_line_run(input bit closing);
    int unsigned n;
    item_t       it;
    n = line_len;
    if (closing && n > MAX_RESULTS - 1) begin
      n = MAX_RESULTS - 1;
    end else if (n > MAX_RESULTS) begin
      n = MAX_RESULTS;
    end
    for (int unsigned i = 0; i < n; i++) begin
      it.kind          = KIND_TEXT;
      it.char_out      = line_chars[ADDR_W'(i)];
      it.last_of_run   = !closing && (i + 1 == n);
      it.utterance_end = 1'b0;
      expected_items.push_back(it);
    end
    if (closing) begin
      expected_items.push_back(item_t'{KIND_TEXT, CH_VT, 1'b1, 1'b1});
    end
    line_len = 0;
  endtask

  // Applies one accepted byte to the shadow line and queues what it causes.
  task automatic predict_byte(input logic [7:0] raw);
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] stored;
    ch = raw[CHAR_W-1:0];
    if (raw == STOP_HI || raw == STOP_ETX) begin
      line_len = 0;
      expected_items.push_back(item_t'{KIND_STOP, '0, 1'b1, 1'b0});
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
      end
    end else if (ch == CH_CR || ch == CH_LF || ch == CH_VT) begin
      if (line_len > 0) begin
        emit_line_run(1'b1);
      end
    end else if (ch == CH_TAB || ch >= CH_SPACE) begin
      stored = (ch == CH_TAB) ? CH_SPACE : ch;
      if (line_len >= LINE_CAP - 2) begin
        emit_line_run(1'b0);
      end
      line_chars[ADDR_W'(line_len)] = stored;
      line_len++;
    end
  endtask

  // Compares one delivered item with the oldest pending expectation.
  task automatic check_result(input item_t got);
    item_t want;
    results_seen++;
    if (expected_items.size() == 0) begin
      error_count++;
      $error("unexpected item: kind %0d char_out 0x%02h last_of_run %0d utterance_end %0d",
             got.kind, got.char_out, got.last_of_run, got.utterance_end);
    end else begin
      want = expected_items.pop_front();
      if (got.kind !== want.kind) begin
        error_count++;
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      end
      if (got.char_out !== want.char_out) begin
        error_count++;
        $error("char_out: expected 0x%02h, actual 0x%02h", want.char_out, got.char_out);
      end
      if (got.last_of_run !== want.last_of_run) begin
        error_count++;
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
      end
      if (got.utterance_end !== want.utterance_end) begin
        error_count++;
        $error("utterance_end: expected %0d, actual %0d",
               want.utterance_end, got.utterance_end);
      end
    end
  endtask

  // Byte driver: holds an offered item until taken, then idles or offers the next one.
  always @(posedge clk) begin : byte_driver
    int r;
    if (rst) begin
      in_valid <= 1'b0;
      byte_in  <= 8'h00;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        predict_byte(byte_in);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid <= 1'b1;
        byte_in  <= pending_bytes.pop_front();
        if (send_quiet > 0) begin
          send_quiet--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            send_quiet = $urandom_range(10, 40);
          end else if (r >= 55) begin
            send_gap = pick_gap_len();
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks every delivered item and throttles out_ready.
  always @(posedge clk) begin : result_monitor
    int r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(item_t'{kind, char_out, last_of_run, utterance_end});
      end
      // One long hold-off so the block backs up and stalls its input.
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_quiet > 0) begin
          recv_quiet--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 20) begin
            recv_gap = pick_gap_len();
          end else if (r < 24) begin
            recv_quiet = $urandom_range(20, 60);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycle_count, expected_items.size());
      $display("text_line_assembler_top_test: errors");
      $finish;
    end
  end

  // Stimulus: a directed opening, then random lines, stops and noise.
  initial begin
    logic [7:0] opening[];
    int         target;
    int         pick;
    int         len;
    int         r;

    opening = '{
      8'h48, 8'h69, {1'b0, CH_CR},          // short line, closed by CR
      {1'b0, CH_CR},                        // line end on an empty line
      STOP_HI, STOP_ETX,                    // both stop bytes
      8'h00, 8'h83, 8'h1f,                  // NUL, masked ETX, other control
      8'h61, {1'b0, CH_TAB}, 8'hc1,         // tab becomes space, bit 7 masked
      {1'b0, CH_BS}, 8'hff, 8'h88,          // backspace, DEL, masked backspace
      {1'b0, CH_BS},                        // backspace on an empty line
      8'h7e, 8'h8a,                         // masked LF closes the line
      8'h78, STOP_HI, {1'b0, CH_VT},        // stop in mid-line, then empty VT
      8'h20, 8'h8d                          // space alone, masked CR
    };
    foreach (opening[i]) begin
      pending_bytes.push_back(opening[i]);
    end
    // An overlong line: forces a run without VT, then a one-character line.
    for (int i = 0; i < LINE_CAP - 1; i++) begin
      pending_bytes.push_back(printable_byte());
    end
    pending_bytes.push_back({1'b0, CH_LF});

    target = pending_bytes.size() + RANDOM_ITEMS;
    while (pending_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        // An ordinary line with some edits, usually terminated.
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            pending_bytes.push_back({1'b0, CH_TAB});
          end else if (r < 14) begin
            pending_bytes.push_back({($urandom_range(0, 1) == 1),
                                     ($urandom_range(0, 1) == 1) ? CH_BS : CH_DEL});
          end else begin
            pending_bytes.push_back(printable_byte());
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          r = $urandom_range(0, 2);
          pending_bytes.push_back({($urandom_range(0, 3) == 0),
                                   (r == 0) ? CH_CR : (r == 1) ? CH_LF : CH_VT});
        end
      end else if (pick < 67) begin
        // A line near or past capacity.
        len = $urandom_range(LINE_CAP - 4, LINE_CAP + 2);
        for (int i = 0; i < len; i++) begin
          pending_bytes.push_back(printable_byte());
        end
        pending_bytes.push_back({1'b0, CH_CR});
      end else if (pick < 77) begin
        pending_bytes.push_back(($urandom_range(0, 1) == 1) ? STOP_HI : STOP_ETX);
      end else if (pick < 89) begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        pending_bytes.push_back({($urandom_range(0, 1) == 1), 7'($urandom_range(0, 31))});
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_items.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("text_line_assembler_top_test: clean");
    end else begin
      $display("text_line_assembler_top_test: errors");
    end
    $finish;
  end

endmodule
